/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("implication failed");

`endif

/* hw/rtl/bsfc_pkg.sv */
package bsfc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_BYTE         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_SUBSTITUTE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_SUBSTITUTE = 3'd4;

  // Direction codes
  localparam logic DIR_PACK   = 1'b0;
  localparam logic DIR_UNPACK = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] RST_FLAG_BYTE         = 8'd126;
  localparam logic [7:0] RST_ESCAPE_BYTE       = 8'd125;
  localparam logic [7:0] RST_FLAG_SUBSTITUTE   = 8'd2;
  localparam logic [7:0] RST_ESCAPE_SUBSTITUTE = 8'd1;

  localparam int MAX_RESULTS = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
    logic       error;
    logic       run_last;
  } out_beat_t;

  typedef struct packed {
    logic       direction;
    logic [7:0] flag_byte;
    logic [7:0] escape_byte;
    logic [7:0] flag_substitute;
    logic [7:0] escape_substitute;
  } cfg_t;

  // One classified input byte: the result bytes it causes, in order.
  // packet_end and error apply to the last result of the job only.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [1:0]                  last_idx;
    logic                        pkt_end;
    logic                        err;
  } job_t;

endpackage

/* hw/rtl/bsfc_front.sv */
`include "assert_macros.svh"

module bsfc_front (
  input  logic              clk,
  input  logic              rst,
  input  bsfc_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  bsfc_pkg::in_beat_t in_beat,
  input  logic              q_ready,
  output logic              push,
  output bsfc_pkg::job_t    job
);

  logic at_packet_start, at_packet_start_next;
  logic escape_pending, escape_pending_next;
  logic discarding, discarding_next;

  logic [bsfc_pkg::MAX_RESULTS-1:0][7:0] seq;
  logic [2:0] n;
  logic       pkt_end;
  logic       err;
  logic       fail;
  logic       accept;
  logic [7:0] b;
  logic       last;

  assign b        = in_beat.in_byte;
  assign last     = in_beat.in_last;
  assign in_stall = !q_ready;
  assign accept   = in_valid && q_ready;

  always_comb begin
    seq                  = '0;
    n                    = 3'd0;
    pkt_end              = 1'b0;
    err                  = 1'b0;
    fail                 = 1'b0;
    at_packet_start_next = at_packet_start;
    escape_pending_next  = escape_pending;
    discarding_next      = discarding;

    if (cfg.direction == bsfc_pkg::DIR_PACK) begin
      if (at_packet_start) begin
        seq[n[1:0]] = cfg.flag_byte;
        n           = n + 3'd1;
      end
      if (b == cfg.flag_byte) begin
        seq[n[1:0]] = cfg.escape_byte;
        n           = n + 3'd1;
        seq[n[1:0]] = cfg.flag_substitute;
        n           = n + 3'd1;
      end else if (b == cfg.escape_byte) begin
        seq[n[1:0]] = cfg.escape_byte;
        n           = n + 3'd1;
        seq[n[1:0]] = cfg.escape_substitute;
        n           = n + 3'd1;
      end else begin
        seq[n[1:0]] = b;
        n           = n + 3'd1;
      end
      if (last) begin
        seq[n[1:0]] = cfg.flag_byte;
        n           = n + 3'd1;
        pkt_end     = 1'b1;
      end
    end else begin
      if (discarding) begin
        // drop the rest of a failed packet
      end else if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (b == cfg.flag_substitute) begin
          seq[0]  = cfg.flag_byte;
          n       = 3'd1;
          pkt_end = last;
        end else if (b == cfg.escape_substitute) begin
          seq[0]  = cfg.escape_byte;
          n       = 3'd1;
          pkt_end = last;
        end else begin
          fail = 1'b1;
        end
      end else if (b == cfg.escape_byte) begin
        if (last) begin
          fail = 1'b1;
        end else begin
          escape_pending_next = 1'b1;
        end
      end else if (b == cfg.flag_byte) begin
        fail = 1'b1;
      end else begin
        seq[0]  = b;
        n       = 3'd1;
        pkt_end = last;
      end
      if (fail) begin
        seq[0]          = 8'd0;
        n               = 3'd1;
        pkt_end         = 1'b1;
        err             = 1'b1;
        discarding_next = 1'b1;
      end
    end

    if (last) begin
      at_packet_start_next = 1'b1;
      escape_pending_next  = 1'b0;
      discarding_next      = 1'b0;
    end else begin
      at_packet_start_next = 1'b0;
    end
  end

  assign job.bytes    = seq;
  assign job.last_idx = n[1:0] - 2'd1;
  assign job.pkt_end  = pkt_end;
  assign job.err      = err;
  assign push         = accept && (n != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      at_packet_start <= 1'b1;
      escape_pending  <= 1'b0;
      discarding      <= 1'b0;
    end else if (accept) begin
      at_packet_start <= at_packet_start_next;
      escape_pending  <= escape_pending_next;
      discarding      <= discarding_next;
    end
  end

  `ASSERT_IMPLIES(a_err_single, clk, rst, push && job.err,
    job.last_idx == 2'd0 && job.pkt_end && job.bytes[0] == 8'd0)

endmodule

/* hw/rtl/bsfc_queue.sv */
`include "assert_macros.svh"

module bsfc_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bsfc_pkg::job_t push_job,
  output logic           ready,
  input  logic           pop,
  output logic           head_valid,
  output bsfc_pkg::job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bsfc_pkg::job_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign ready      = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, !ready, !push)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, !head_valid, !pop)

endmodule

/* hw/rtl/bsfc_back.sv */
`include "assert_macros.svh"

module bsfc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  bsfc_pkg::job_t      head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output bsfc_pkg::out_beat_t out_beat
);

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign load   = head_valid && (!out_valid || !out_stall);
  assign at_end = (idx == head.last_idx);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (!out_valid || !out_stall) begin
        out_valid <= head_valid;
      end
      if (load) begin
        idx <= at_end ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_beat.out_byte   <= head.bytes[idx];
      out_beat.packet_end <= at_end && head.pkt_end;
      out_beat.error      <= at_end && head.err;
      out_beat.run_last   <= at_end;
    end
  end

  `ASSERT_IMPLIES(a_err_closes, clk, rst, out_valid && out_beat.error,
    out_beat.packet_end && out_beat.run_last)

endmodule

/* hw/rtl/byte_stuffing_frame_codec_unit.sv */
// Channel   Direction  Payload      Handshake
// --------  ---------  -----------  -----------------------------------
// in        input      in_beat      in_valid / in_stall
// out       output     out_beat     out_valid / out_stall
// cfg       input      cfg_data     cfg_we, cfg_index (write only)
//
// An input byte causes one to four output beats (none when unpacking drops
// a byte or holds an escape). The back end sends one beat per cycle while
// out_stall is low. The first output beat of an accepted byte passes
// through a queue slot, then the output register. The input stalls only
// when the job queue is full. rst is synchronous: registers return to
// defaults, queue empties, state goes to packet start. A stalled output
// holds its beat; the front keeps taking bytes until QUEUE_DEPTH
// jobs wait.

module byte_stuffing_frame_codec_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  bsfc_pkg::in_beat_t                   in_beat,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output bsfc_pkg::out_beat_t                  out_beat,
  input  logic                                 cfg_we,
  input  logic [bsfc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsfc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  bsfc_pkg::cfg_t cfg;
  bsfc_pkg::job_t push_job;
  bsfc_pkg::job_t head;
  logic           push;
  logic           pop;
  logic           q_ready;
  logic           head_valid;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction         <= bsfc_pkg::DIR_PACK;
      cfg.flag_byte         <= bsfc_pkg::RST_FLAG_BYTE;
      cfg.escape_byte       <= bsfc_pkg::RST_ESCAPE_BYTE;
      cfg.flag_substitute   <= bsfc_pkg::RST_FLAG_SUBSTITUTE;
      cfg.escape_substitute <= bsfc_pkg::RST_ESCAPE_SUBSTITUTE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsfc_pkg::REG_DIRECTION:         cfg.direction         <= cfg_data[0];
        bsfc_pkg::REG_FLAG_BYTE:         cfg.flag_byte         <= cfg_data[7:0];
        bsfc_pkg::REG_ESCAPE_BYTE:       cfg.escape_byte       <= cfg_data[7:0];
        bsfc_pkg::REG_FLAG_SUBSTITUTE:   cfg.flag_substitute   <= cfg_data[7:0];
        bsfc_pkg::REG_ESCAPE_SUBSTITUTE: cfg.escape_substitute <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Front: classify each byte, track packet state, build the job.
  bsfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .q_ready  (q_ready),
    .push     (push),
    .job      (push_job)
  );

  // Short job queue decouples input stalls from output stalls.
  bsfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: advance through a job's bytes, one beat per cycle while out_stall is low.
  bsfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_beat   (out_beat)
  );

endmodule
